>>> rtl/qmn_pkg.sv
package qmn_pkg;

  // Fixed-point format of every component.
  localparam int FracBits = 29;
  localparam int CompWidth = 32;
  localparam int MagWidth = CompWidth - 1;

  // Symmetric saturation bound of a product component.
  localparam logic signed [CompWidth-1:0] SatMax = 32'sh7FFF_FFFF;

  // Half an output LSB in the Q4.58 product format.
  localparam logic signed [65:0] HalfLsb = 66'sd1 <<< (FracBits - 1);

  // One square-root stage per result bit, one divide stage per quotient bit.
  localparam int SqrtSteps = 32;
  localparam int DivSteps = FracBits + 1;

  // Wide product sum, rounded half up to Q2.29 and saturated.
  function automatic logic signed [CompWidth-1:0] round_sat(input logic signed [65:0] acc);
    logic signed [65:0] r;
    begin
      r = (acc + HalfLsb) >>> FracBits;
      if (r > 66'(SatMax)) begin
        round_sat = SatMax;
      end else if (r < -66'(SatMax)) begin
        round_sat = -SatMax;
      end else begin
        round_sat = r[CompWidth-1:0];
      end
    end
  endfunction

endpackage

>>> rtl/quaternion_multiply_normalize.sv
// Throughput: one transaction per cycle; busy is always low.
// Most of the pipeline depth lies in the 32-stage square root and the 30-stage divider lanes.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module quaternion_multiply_normalize (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [qmn_pkg::CompWidth-1:0] a_x,
  input  logic signed [qmn_pkg::CompWidth-1:0] a_y,
  input  logic signed [qmn_pkg::CompWidth-1:0] a_z,
  input  logic signed [qmn_pkg::CompWidth-1:0] a_w,
  input  logic signed [qmn_pkg::CompWidth-1:0] b_x,
  input  logic signed [qmn_pkg::CompWidth-1:0] b_y,
  input  logic signed [qmn_pkg::CompWidth-1:0] b_z,
  input  logic signed [qmn_pkg::CompWidth-1:0] b_w,
  output logic                               done,
  output logic signed [qmn_pkg::CompWidth-1:0] p_x,
  output logic signed [qmn_pkg::CompWidth-1:0] p_y,
  output logic signed [qmn_pkg::CompWidth-1:0] p_z,
  output logic signed [qmn_pkg::CompWidth-1:0] p_w,
  output logic                               degenerate
);
  import qmn_pkg::*;

  localparam int SqrtTop = 2 * SqrtSteps - 2;
  localparam int NumWidth = MagWidth + FracBits + 1;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 1: the sixteen partial products.
  logic                        v1;
  logic signed [63:0]          prod [16];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    prod[0]  <= a_w * b_x;  prod[1]  <= a_z * b_y;
    prod[2]  <= a_y * b_z;  prod[3]  <= a_x * b_w;
    prod[4]  <= a_z * b_x;  prod[5]  <= a_w * b_y;
    prod[6]  <= a_x * b_z;  prod[7]  <= a_y * b_w;
    prod[8]  <= a_y * b_x;  prod[9]  <= a_x * b_y;
    prod[10] <= a_w * b_z;  prod[11] <= a_z * b_w;
    prod[12] <= a_x * b_x;  prod[13] <= a_y * b_y;
    prod[14] <= a_z * b_z;  prod[15] <= a_w * b_w;
  end

  // Stage 2: signed sums, rounding and saturation.
  logic                        v2;
  logic signed [CompWidth-1:0] t [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    t[0] <= round_sat(66'(prod[0]) - 66'(prod[1]) + 66'(prod[2]) + 66'(prod[3]));
    t[1] <= round_sat(66'(prod[4]) + 66'(prod[5]) - 66'(prod[6]) + 66'(prod[7]));
    t[2] <= round_sat(-66'(prod[8]) + 66'(prod[9]) + 66'(prod[10]) + 66'(prod[11]));
    t[3] <= round_sat(-66'(prod[12]) - 66'(prod[13]) - 66'(prod[14]) + 66'(prod[15]));
  end

  // Stage 3: magnitudes, signs and the common normalizing shift.
  logic                        v3;
  logic [MagWidth-1:0]         mag [4];
  logic [3:0]                  neg3;
  logic                        zero3;
  logic [4:0]                  sh3;
  logic [MagWidth-1:0]         mag_all;
  logic [4:0]                  sh_next;

  always_comb begin
    mag_all = '0;
    for (int i = 0; i < 4; i++) begin
      mag_all = mag_all | (t[i][CompWidth-1] ? MagWidth'(-t[i]) : MagWidth'(t[i]));
    end
    sh_next = '0;
    for (int b = 0; b < MagWidth; b++) begin
      if (mag_all[b]) begin
        sh_next = 5'(MagWidth - 1 - b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    for (int i = 0; i < 4; i++) begin
      mag[i]  <= t[i][CompWidth-1] ? MagWidth'(-t[i]) : MagWidth'(t[i]);
      neg3[i] <= t[i][CompWidth-1];
    end
    zero3 <= (mag_all == '0);
    sh3   <= sh_next;
  end

  // Stage 4: shift the magnitudes so the largest lies in [2^30, 2^31).
  logic                        v4;
  logic [MagWidth-1:0]         u4 [4];
  logic [3:0]                  neg4;
  logic                        zero4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    for (int i = 0; i < 4; i++) begin
      u4[i] <= mag[i] << sh3;
    end
    neg4  <= neg3;
    zero4 <= zero3;
  end

  // Stage 5: squares.
  logic                        v5;
  logic [2*MagWidth-1:0]       sq [4];
  logic [MagWidth-1:0]         u5 [4];
  logic [3:0]                  neg5;
  logic                        zero5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    for (int i = 0; i < 4; i++) begin
      sq[i] <= u4[i] * u4[i];
      u5[i] <= u4[i];
    end
    neg5  <= neg4;
    zero5 <= zero4;
  end

  // Square-root pipeline: index 0 holds the sum of squares.
  logic                        sv   [SqrtSteps+1];
  logic [63:0]                 srem [SqrtSteps+1];
  logic [63:0]                 sres [SqrtSteps+1];
  logic [MagWidth-1:0]         su   [SqrtSteps+1][4];
  logic [3:0]                  sneg [SqrtSteps+1];
  logic                        szero[SqrtSteps+1];
  logic [63:0]                 srem_next [SqrtSteps];
  logic [63:0]                 sres_next [SqrtSteps];
  logic [63:0]                 trial;

  always_comb begin
    for (int k = 0; k < SqrtSteps; k++) begin
      trial = sres[k] + (64'd1 << (SqrtTop - 2 * k));
      if (srem[k] >= trial) begin
        srem_next[k] = srem[k] - trial;
        sres_next[k] = (sres[k] >> 1) + (64'd1 << (SqrtTop - 2 * k));
      end else begin
        srem_next[k] = srem[k];
        sres_next[k] = sres[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SqrtSteps; k++) begin
        sv[k] <= 1'b0;
      end
    end else begin
      sv[0] <= v5;
      for (int k = 0; k < SqrtSteps; k++) begin
        sv[k+1] <= sv[k];
      end
    end
    srem[0]  <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]) + 64'(sq[3]);
    sres[0]  <= '0;
    su[0]    <= u5;
    sneg[0]  <= neg5;
    szero[0] <= zero5;
    for (int k = 0; k < SqrtSteps; k++) begin
      srem[k+1]  <= srem_next[k];
      sres[k+1]  <= sres_next[k];
      su[k+1]    <= su[k];
      sneg[k+1]  <= sneg[k];
      szero[k+1] <= szero[k];
    end
  end

  // Divider lanes: index 0 holds the rounded dividends and the norm.
  logic                        dv   [DivSteps+1];
  logic [NumWidth-1:0]         drem [DivSteps+1][4];
  logic [DivSteps-1:0]         dq   [DivSteps+1][4];
  logic [31:0]                 dnorm[DivSteps+1];
  logic [3:0]                  dneg [DivSteps+1];
  logic                        dzero[DivSteps+1];
  logic [NumWidth-1:0]         drem_next [DivSteps][4];
  logic                        dbit [DivSteps][4];
  logic [NumWidth:0]           dcmp;

  always_comb begin
    for (int j = 0; j < DivSteps; j++) begin
      dcmp = (NumWidth+1)'(dnorm[j]) << (DivSteps - 1 - j);
      for (int i = 0; i < 4; i++) begin
        dbit[j][i] = ({1'b0, drem[j][i]} >= dcmp);
        drem_next[j][i] = dbit[j][i] ? NumWidth'({1'b0, drem[j][i]} - dcmp) : drem[j][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= DivSteps; j++) begin
        dv[j] <= 1'b0;
      end
    end else begin
      dv[0] <= sv[SqrtSteps];
      for (int j = 0; j < DivSteps; j++) begin
        dv[j+1] <= dv[j];
      end
    end
    for (int i = 0; i < 4; i++) begin
      drem[0][i] <= {su[SqrtSteps][i], FracBits'(0)} + NumWidth'(sres[SqrtSteps][31:1]);
      dq[0][i]   <= '0;
    end
    dnorm[0] <= sres[SqrtSteps][31:0];
    dneg[0]  <= sneg[SqrtSteps];
    dzero[0] <= szero[SqrtSteps];
    for (int j = 0; j < DivSteps; j++) begin
      for (int i = 0; i < 4; i++) begin
        drem[j+1][i] <= drem_next[j][i];
        dq[j+1][i]   <= {dq[j][i][DivSteps-2:0], dbit[j][i]};
      end
      dnorm[j+1] <= dnorm[j];
      dneg[j+1]  <= dneg[j];
      dzero[j+1] <= dzero[j];
    end
  end

  // Output stage: apply signs, or pass a zero product through.
  logic signed [CompWidth-1:0] res_val [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dzero[DivSteps]) begin
        res_val[i] = '0;
      end else if (dneg[DivSteps][i]) begin
        res_val[i] = -CompWidth'(dq[DivSteps][i]);
      end else begin
        res_val[i] = CompWidth'(dq[DivSteps][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv[DivSteps];
    end
    p_x        <= res_val[0];
    p_y        <= res_val[1];
    p_z        <= res_val[2];
    p_w        <= res_val[3];
    degenerate <= dzero[DivSteps];
  end

endmodule
